[rtl/ufpc_pkg.sv]
// Shared types and helpers for the union-find engine.
// No dependencies; imported by the top level and the find engine.
package ufpc_pkg;

    localparam logic MODE_UNION = 1'b0;
    localparam logic MODE_FIND  = 1'b1;

    // Parent-store request word: one read port and one write port.
    typedef struct packed {
        logic       rd_en;
        logic [7:0] rd_addr;
        logic       wr_en;
        logic [7:0] wr_addr;
        logic [7:0] wr_data;
    } t_mem_req;

    typedef struct packed {
        logic       start;
        logic [7:0] elem;
    } t_find_cmd;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] root;
    } t_find_sts;

    // Element 0 is the no-parent mark; numbers at or above the limit are out of range.
    function automatic logic elem_ok(input logic [7:0] e, input logic [8:0] lim);
        return (e != 8'd0) && ({1'b0, e} < lim);
    endfunction

endpackage

[rtl/ufpc_req_if.sv]
// Request channel of the union-find engine: valid/ready plus the request word.
// No dependencies.
interface ufpc_req_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] elem_a;
    logic [7:0] elem_b;

    modport source(output valid, mode, elem_a, elem_b, input ready);
    modport sink(input valid, mode, elem_a, elem_b, output ready);
endinterface

[rtl/ufpc_rsp_if.sv]
// Response channel of the union-find engine: valid/ready plus the result word.
// No dependencies.
interface ufpc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] root_a;
    logic [7:0] root_b;
    logic       merged;

    modport source(output valid, root_a, root_b, merged, input ready);
    modport sink(input valid, root_a, root_b, merged, output ready);
endinterface

[rtl/union_find_path_compression.sv]
// Union-find engine top level: sequencer, parent-store RAM and result register.
// Depends on ufpc_pkg, ufpc_req_if, ufpc_rsp_if, ufpc_ram and ufpc_find.
//
// Usage:
//   i_req carries one request word: mode (0 union, 1 find), elem_a, elem_b.
//   o_rsp returns exactly one word per request: root_a, root_b (0 on find)
//   and merged (1 when a union joined two different sets).
//   Both channels move a word on a clock edge with valid and ready high.
// Operation:
//   One request is in flight at a time. A find walks the element's path to
//   the root with one RAM read per step of the walk, then repoints the
//   walked nodes with one read plus write per repointed node; out-of-range
//   elements skip the walk. A union runs two finds back to back and links
//   when the second find is done, then the result register is loaded.
// Reset:
//   i_rst_n is synchronous, active low. After reset a clearing pass writes
//   zero into every store entry, one per cycle; i_req.ready stays low until
//   it finishes.
// Stall:
//   A finished word waits in the result register while the next request is
//   accepted and worked on; the engine only holds when a second result is
//   ready before the first one has been taken.
module union_find_path_compression import ufpc_pkg::*; #(
    parameter int NUM_ELEMENTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ufpc_req_if.sink    i_req,
    ufpc_rsp_if.source  o_rsp
);

    localparam int         Depth   = (NUM_ELEMENTS > 256) ? 256 : NUM_ELEMENTS;
    localparam int         AddrW   = $clog2(Depth);
    localparam logic [8:0] ElemLim = 9'(Depth);

    typedef enum logic [4:0] {
        T_CLEAR  = 5'b00001,
        T_IDLE   = 5'b00010,
        T_FIND_A = 5'b00100,
        T_FIND_B = 5'b01000,
        T_OUT    = 5'b10000
    } t_tstate;

    t_tstate          r_state, n_state;
    logic [AddrW-1:0] r_clr_addr, n_clr_addr;
    logic             r_mode, n_mode;
    logic [7:0]       r_b, n_b;
    logic [7:0]       r_ra, n_ra;
    logic [7:0]       r_rb, n_rb;
    logic             r_merged, n_merged;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_root_a, n_out_root_a;
    logic [7:0]       r_out_root_b, n_out_root_b;
    logic             r_out_merged, n_out_merged;

    t_find_cmd  w_cmd;
    t_find_sts  w_sts;
    t_mem_req   w_find_mem;
    t_mem_req   w_mem;
    logic [7:0] w_rd_data;

    ufpc_find #(
        .NUM_ELEMENTS(NUM_ELEMENTS)
    ) u_find (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_mem     (w_find_mem),
        .i_rd_data (w_rd_data)
    );

    ufpc_ram #(
        .WIDTH(8),
        .DEPTH(Depth)
    ) u_parent_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem.wr_en),
        .i_wr_addr (w_mem.wr_addr[AddrW-1:0]),
        .i_wr_data (w_mem.wr_data),
        .i_rd_en   (w_mem.rd_en),
        .i_rd_addr (w_mem.rd_addr[AddrW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign i_req.ready = (r_state == T_IDLE);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_mode       = r_mode;
        n_b          = r_b;
        n_ra         = r_ra;
        n_rb         = r_rb;
        n_merged     = r_merged;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_root_a = r_out_root_a;
        n_out_root_b = r_out_root_b;
        n_out_merged = r_out_merged;
        w_cmd        = '0;
        w_mem        = w_find_mem;
        case (r_state)
            T_CLEAR: begin
                w_mem.wr_en   = 1'b1;
                w_mem.wr_addr = 8'(r_clr_addr);
                w_mem.wr_data = 8'd0;
                n_clr_addr    = r_clr_addr + 1'b1;
                if (r_clr_addr == AddrW'(Depth - 1)) begin
                    n_state = T_IDLE;
                end
            end
            T_IDLE: begin
                if (i_req.valid) begin
                    n_mode     = i_req.mode;
                    n_b        = i_req.elem_b;
                    w_cmd.start = 1'b1;
                    w_cmd.elem  = i_req.elem_a;
                    n_state    = T_FIND_A;
                end
            end
            T_FIND_A: begin
                if (w_sts.done) begin
                    n_ra = w_sts.root;
                    if (r_mode == MODE_FIND) begin
                        n_rb     = 8'd0;
                        n_merged = 1'b0;
                        n_state  = T_OUT;
                    end else begin
                        w_cmd.start = 1'b1;
                        w_cmd.elem  = r_b;
                        n_state     = T_FIND_B;
                    end
                end
            end
            T_FIND_B: begin
                if (w_sts.done) begin
                    n_rb     = w_sts.root;
                    n_merged = 1'b0;
                    if ((r_ra != w_sts.root) && elem_ok(r_ra, ElemLim)
                            && elem_ok(w_sts.root, ElemLim)) begin
                        // hang root of b under root of a
                        w_mem.wr_en   = 1'b1;
                        w_mem.wr_addr = w_sts.root;
                        w_mem.wr_data = r_ra;
                        n_merged      = 1'b1;
                    end
                    n_state = T_OUT;
                end
            end
            T_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_root_a = r_ra;
                    n_out_root_b = r_rb;
                    n_out_merged = r_merged;
                    n_state      = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_b          <= n_b;
        r_ra         <= n_ra;
        r_rb         <= n_rb;
        r_merged     <= n_merged;
        r_out_root_a <= n_out_root_a;
        r_out_root_b <= n_out_root_b;
        r_out_merged <= n_out_merged;
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.root_a = r_out_root_a;
    assign o_rsp.root_b = r_out_root_b;
    assign o_rsp.merged = r_out_merged;

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |-> !w_sts.busy)
        else $error("find engine started while walking");

    a_accept_starts_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (w_sts.busy || w_sts.done))
        else $error("accepted word did not start a find");

    a_link_port_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_FIND_B && w_sts.done) |-> (!w_find_mem.rd_en && !w_find_mem.wr_en))
        else $error("link write collides with find traffic");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_CLEAR) |-> (!w_sts.busy && !w_cmd.start))
        else $error("find activity during clearing pass");

    a_merge_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.merged) |->
            (o_rsp.root_a != o_rsp.root_b && o_rsp.root_a != 8'd0 && o_rsp.root_b != 8'd0))
        else $error("merge reported for equal or null roots");

endmodule

[rtl/ufpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ufpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/ufpc_find.sv]
// Find engine: walks the parent store to the root, then repoints the walked path.
// Depends on ufpc_pkg; drives the parent-store RAM through a t_mem_req word.
module ufpc_find import ufpc_pkg::*; #(
    parameter int NUM_ELEMENTS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_find_cmd  i_cmd,
    output t_find_sts  o_sts,
    output t_mem_req   o_mem,
    input  logic [7:0] i_rd_data
);

    localparam logic [8:0] ElemLim = 9'((NUM_ELEMENTS > 256) ? 256 : NUM_ELEMENTS);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_WALK = 4'b0010,
        F_COMP = 4'b0100,
        F_DONE = 4'b1000
    } t_fstate;

    t_fstate    r_state, n_state;
    logic [7:0] r_elem, n_elem;
    logic [7:0] r_cur,  n_cur;
    logic [7:0] r_root, n_root;
    logic       w_next_ok;
    t_mem_req   w_mem;

    // parent read back is a real link (not the root mark, not out of range)
    assign w_next_ok = elem_ok(i_rd_data, ElemLim);

    always_comb begin
        n_state = r_state;
        n_elem  = r_elem;
        n_cur   = r_cur;
        n_root  = r_root;
        w_mem   = '0;
        case (r_state)
            F_IDLE, F_DONE: begin
                n_state = F_IDLE;
                if (i_cmd.start) begin
                    n_elem = i_cmd.elem;
                    if (elem_ok(i_cmd.elem, ElemLim)) begin
                        n_cur         = i_cmd.elem;
                        w_mem.rd_en   = 1'b1;
                        w_mem.rd_addr = i_cmd.elem;
                        n_state       = F_WALK;
                    end else begin
                        n_root  = i_cmd.elem;
                        n_state = F_DONE;
                    end
                end
            end
            F_WALK: begin
                if (w_next_ok) begin
                    n_cur         = i_rd_data;
                    w_mem.rd_en   = 1'b1;
                    w_mem.rd_addr = i_rd_data;
                end else begin
                    n_root = r_cur;
                    if (r_elem == r_cur) begin
                        n_state = F_DONE;
                    end else begin
                        // second pass from the start element
                        n_cur         = r_elem;
                        w_mem.rd_en   = 1'b1;
                        w_mem.rd_addr = r_elem;
                        n_state       = F_COMP;
                    end
                end
            end
            F_COMP: begin
                if (!w_next_ok) begin
                    n_state = F_DONE;
                end else begin
                    w_mem.wr_en   = 1'b1;
                    w_mem.wr_addr = r_cur;
                    w_mem.wr_data = r_root;
                    if (i_rd_data == r_root) begin
                        n_state = F_DONE;
                    end else begin
                        n_cur         = i_rd_data;
                        w_mem.rd_en   = 1'b1;
                        w_mem.rd_addr = i_rd_data;
                    end
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem <= n_elem;
        r_cur  <= n_cur;
        r_root <= n_root;
    end

    assign o_mem       = w_mem;
    assign o_sts.busy  = (r_state == F_WALK) || (r_state == F_COMP);
    assign o_sts.done  = (r_state == F_DONE);
    assign o_sts.root  = r_root;

endmodule
